>>> src/nested_comment_string_lexer_unit_assert.svh
// Assertion macros shared by the lexer RTL.
`ifndef NESTED_COMMENT_STRING_LEXER_UNIT_ASSERT_SVH
`define NESTED_COMMENT_STRING_LEXER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Antecedent true implies consequent true in the same cycle.
`define NCSL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Antecedent true implies consequent true in the next cycle.
`define NCSL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NCSL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define NCSL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> src/ncsl_pkg.sv
// Package with types and constants of the nested comment and string lexer.
`timescale 1ns / 1ps
`default_nettype none
package ncsl_pkg;

    localparam int unsigned MAX_LINE_DEF  = 4096;
    localparam int unsigned MAX_DEPTH_DEF = 255;

    localparam int unsigned CHAR_W  = 16;
    localparam int unsigned START_W = 12;
    localparam int unsigned LEN_W   = 13;
    localparam int unsigned DEPTH_W = 8;

    localparam logic [CHAR_W-1:0] CH_BACKSLASH = 16'h005C;
    localparam logic [CHAR_W-1:0] CH_QUOTE     = 16'h0022;
    localparam logic [CHAR_W-1:0] CH_SLASH     = 16'h002F;
    localparam logic [CHAR_W-1:0] CH_STAR      = 16'h002A;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_STRING  = 2'd1,
        KIND_COMMENT = 2'd2,
        KIND_ERROR   = 2'd3
    } t_span_kind;

endpackage
`default_nettype wire

>>> src/nested_comment_string_lexer_unit.sv
// Top level of the nested block comment and string lexer.
// An accepted input transaction passes the input register and the result register.
// Throughput: one character per cycle unless stalled; the input register, one pass of compare and
// counter logic, and the result register keep a new character entering every cycle.
// A result waiting under stall holds the pipeline only when the next character has one too.
// Reset (i_rst_n low, synchronous) clears the lexer state and both valid flags.
`timescale 1ns / 1ps
`default_nettype none
`include "nested_comment_string_lexer_unit_assert.svh"
module nested_comment_string_lexer_unit #(
    parameter int unsigned MAX_LINE  = ncsl_pkg::MAX_LINE_DEF,
    parameter int unsigned MAX_DEPTH = ncsl_pkg::MAX_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Input channel: one character per transaction.
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [ncsl_pkg::CHAR_W-1:0]   i_char_code,
    input  wire logic                          i_end_of_line,
    // Output channel: at most one span report per character.
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [1:0]                         o_span_kind,
    output logic [ncsl_pkg::START_W-1:0]       o_span_start,
    output logic [ncsl_pkg::LEN_W-1:0]         o_span_length,
    output logic                               o_line_done,
    output logic                               o_end_in_string,
    output logic [ncsl_pkg::DEPTH_W-1:0]       o_end_comment_depth,
    output logic                               o_overflow
);

    // PW holds a position below MAX_LINE, LW a count up to MAX_LINE itself.
    localparam int unsigned PW = $clog2(MAX_LINE);
    localparam int unsigned LW = $clog2(MAX_LINE + 1);
    localparam int unsigned DW = $clog2(MAX_DEPTH + 1);

    localparam logic [PW-1:0] LAST_POS  = PW'(MAX_LINE - 1);
    localparam logic [LW-1:0] LINE_MAX  = LW'(MAX_LINE);
    localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_DEPTH);
    localparam logic [DW-1:0] DEPTH_ONE = DW'(1);

    // Input register.
    logic                        r_in_valid;
    logic [ncsl_pkg::CHAR_W-1:0] r_char;
    logic                        r_eol;

    // Lexer state that carries from character to character.
    logic          r_in_string,     n_in_string;
    logic [DW-1:0] r_comment_depth, n_comment_depth;
    logic          r_skip_next,     n_skip_next;
    logic          r_pending_slash, n_pending_slash;
    logic          r_pending_star,  n_pending_star;
    logic [PW-1:0] r_open_start,    n_open_start;
    logic [LW-1:0] r_line_position, n_line_position;
    logic          r_overflow_seen, n_overflow_seen;

    // Result register.
    logic                         r_out_valid;
    ncsl_pkg::t_span_kind         r_kind;
    logic [ncsl_pkg::START_W-1:0] r_start;
    logic [ncsl_pkg::LEN_W-1:0]   r_length;
    logic                         r_line_done;
    logic                         r_end_in_string;
    logic [ncsl_pkg::DEPTH_W-1:0] r_end_depth;
    logic                         r_end_overflow;

    // Values computed for the character in the input register.
    ncsl_pkg::t_span_kind n_kind;
    logic [PW-1:0]        n_start;
    logic [LW-1:0]        n_length;
    logic                 has_result;
    logic                 advance;
    logic                 at_max;
    logic [PW-1:0]        cur_pos;
    logic [PW-1:0]        prev_pos;
    logic [LW-1:0]        end_pos;
    logic                 ovf_now;

    // The character moves on unless it has a result and the result register
    // still holds one that the downstream side is stalling.
    assign has_result = r_eol || (n_kind != ncsl_pkg::KIND_NONE);
    assign advance    = r_in_valid && (!has_result || !r_out_valid || !i_stall);
    assign o_stall    = r_in_valid && !advance;

    // Position of this character; past MAX_LINE characters it is pinned to the
    // last position and spans are clipped to end at MAX_LINE.
    assign at_max   = (r_line_position == LINE_MAX);
    assign cur_pos  = at_max ? LAST_POS : r_line_position[PW-1:0];
    assign prev_pos = (r_line_position == '0) ? '0 :
                      (at_max ? LAST_POS : PW'(r_line_position - LW'(1)));
    assign end_pos  = at_max ? LINE_MAX : (r_line_position + LW'(1));

    always_comb begin
        n_in_string     = r_in_string;
        n_comment_depth = r_comment_depth;
        n_skip_next     = r_skip_next;
        n_pending_slash = r_pending_slash;
        n_pending_star  = r_pending_star;
        n_open_start    = r_open_start;
        n_kind          = ncsl_pkg::KIND_NONE;
        n_start         = '0;
        n_length        = '0;
        ovf_now         = r_overflow_seen || at_max;

        // An escaped character is inert; a pending slash or star may complete a
        // two-character marker; otherwise the character is classified alone.
        priority if (r_skip_next) begin
            n_skip_next = 1'b0;
        end else if (r_pending_slash && (r_char == ncsl_pkg::CH_STAR)) begin
            n_pending_slash = 1'b0;
            if (r_comment_depth == '0) begin
                n_open_start = prev_pos;
            end
            if (r_comment_depth < DEPTH_MAX) begin
                n_comment_depth = r_comment_depth + DEPTH_ONE;
            end else begin
                ovf_now = 1'b1;
            end
        end else if (r_pending_star && (r_char == ncsl_pkg::CH_SLASH)) begin
            n_pending_star = 1'b0;
            if (r_comment_depth == '0) begin
                // A closer with no comment open is reported as an error span.
                n_kind   = ncsl_pkg::KIND_ERROR;
                n_start  = prev_pos;
                n_length = end_pos - LW'(prev_pos);
            end else begin
                if (r_comment_depth == DEPTH_ONE) begin
                    n_kind   = ncsl_pkg::KIND_COMMENT;
                    n_start  = r_open_start;
                    n_length = end_pos - LW'(r_open_start);
                end
                n_comment_depth = r_comment_depth - DEPTH_ONE;
            end
        end else begin
            n_pending_slash = 1'b0;
            n_pending_star  = 1'b0;
            priority if (r_char == ncsl_pkg::CH_BACKSLASH) begin
                n_skip_next = 1'b1;
            end else if ((r_char == ncsl_pkg::CH_QUOTE) && (r_comment_depth == '0)) begin
                if (!r_in_string) begin
                    n_open_start = cur_pos;
                end else begin
                    n_kind   = ncsl_pkg::KIND_STRING;
                    n_start  = r_open_start;
                    n_length = end_pos - LW'(r_open_start);
                end
                n_in_string = !r_in_string;
            end else if ((r_char == ncsl_pkg::CH_SLASH) && !r_in_string) begin
                n_pending_slash = 1'b1;
            end else if ((r_char == ncsl_pkg::CH_STAR) && !r_in_string) begin
                n_pending_star = 1'b1;
            end else begin
                n_pending_slash = 1'b0;
            end
        end

        n_line_position = at_max ? r_line_position : (r_line_position + LW'(1));
        n_overflow_seen = ovf_now;

        // At the line end any span still open is reported up to the line end,
        // and the marker flags, open start and position start over.
        if (r_eol) begin
            if (n_kind == ncsl_pkg::KIND_NONE) begin
                if (n_in_string) begin
                    n_kind   = ncsl_pkg::KIND_STRING;
                    n_start  = n_open_start;
                    n_length = end_pos - LW'(n_open_start);
                end else if (n_comment_depth != '0) begin
                    n_kind   = ncsl_pkg::KIND_COMMENT;
                    n_start  = n_open_start;
                    n_length = end_pos - LW'(n_open_start);
                end
            end
            n_skip_next     = 1'b0;
            n_pending_slash = 1'b0;
            n_pending_star  = 1'b0;
            n_open_start    = '0;
            n_line_position = '0;
            n_overflow_seen = 1'b0;
        end
    end

    // Input register: loads whenever the held character moves on or none is held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (i_valid && !o_stall) begin
            r_char <= i_char_code;
            r_eol  <= i_end_of_line;
        end
    end

    // Lexer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_string     <= 1'b0;
            r_comment_depth <= '0;
            r_skip_next     <= 1'b0;
            r_pending_slash <= 1'b0;
            r_pending_star  <= 1'b0;
            r_open_start    <= '0;
            r_line_position <= '0;
            r_overflow_seen <= 1'b0;
        end else if (advance) begin
            r_in_string     <= n_in_string;
            r_comment_depth <= n_comment_depth;
            r_skip_next     <= n_skip_next;
            r_pending_slash <= n_pending_slash;
            r_pending_star  <= n_pending_star;
            r_open_start    <= n_open_start;
            r_line_position <= n_line_position;
            r_overflow_seen <= n_overflow_seen;
        end
    end

    // Result register. The line-end fields read zero on a mid-line result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && has_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (advance && has_result) begin
            r_kind          <= n_kind;
            r_start         <= ncsl_pkg::START_W'(n_start);
            r_length        <= ncsl_pkg::LEN_W'(n_length);
            r_line_done     <= r_eol;
            r_end_in_string <= r_eol && n_in_string;
            r_end_depth     <= r_eol ? ncsl_pkg::DEPTH_W'(n_comment_depth) : '0;
            r_end_overflow  <= r_eol && ovf_now;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_span_kind         = r_kind;
    assign o_span_start        = r_start;
    assign o_span_length       = r_length;
    assign o_line_done         = r_line_done;
    assign o_end_in_string     = r_end_in_string;
    assign o_end_comment_depth = r_end_depth;
    assign o_overflow          = r_end_overflow;

    // A mid-line result never carries line-end state.
    `NCSL_ASSERT_IMPLY(a_midline_clean, i_clk, i_rst_n, o_valid && !o_line_done, !o_end_in_string && (o_end_comment_depth == '0) && !o_overflow, "mid-line result carries line-end state")
    // A processed line end restarts the position count.
    `NCSL_ASSERT_NEXT(a_eol_restart, i_clk, i_rst_n, advance && r_eol, (r_line_position == '0) && !r_skip_next && !r_overflow_seen, "line end did not restart the line")
    // Strings open only outside comments and comments only outside strings.
    `NCSL_ASSERT_IMPLY(a_string_comment_excl, i_clk, i_rst_n, r_in_string, r_comment_depth == '0, "string open inside a comment")
    // At most one of escape, pending slash and pending star is armed.
    `NCSL_ASSERT_IMPLY(a_pending_excl, i_clk, i_rst_n, r_skip_next || r_pending_slash || r_pending_star, $onehot({r_skip_next, r_pending_slash, r_pending_star}), "more than one pending marker")

endmodule
`default_nettype wire

>>> verif/tb_nested_comment_string_lexer_unit.sv
// Self-checking testbench for the nested comment and string lexer unit.
`timescale 1ns / 1ps
module tb_nested_comment_string_lexer_unit;

    localparam int unsigned LINE_CAP       = ncsl_pkg::MAX_LINE_DEF;
    localparam int unsigned DEPTH_CAP      = ncsl_pkg::MAX_DEPTH_DEF;
    localparam int          ITEM_GOAL      = 750;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          DIR_N          = 28;
    // Random characters leave room for the directed rows and the two nesting lines.
    localparam int          RAND_GOAL      = ITEM_GOAL - DIR_N - 2 * int'(DEPTH_CAP) - 5;

    // One span report, laid out as the output ports of the block.
    typedef struct packed {
        ncsl_pkg::t_span_kind         kind;
        logic [ncsl_pkg::START_W-1:0] span_start;
        logic [ncsl_pkg::LEN_W-1:0]   span_len;
        logic                         done;
        logic                         in_str;
        logic [ncsl_pkg::DEPTH_W-1:0] depth;
        logic                         ovf;
    } t_span_rep;

    // One character of stimulus; a pinned row carries its report typed in by hand.
    typedef struct packed {
        logic [ncsl_pkg::CHAR_W-1:0] ch;
        logic                        eol;
        logic                        pinned;
        t_span_rep                   rep;
    } t_dir_row;

    localparam t_span_rep NO_SPAN = '0;

    localparam t_dir_row DIR_TAB [DIR_N] = '{
        // A short string, then an empty comment closed on the last character.
        '{ncsl_pkg::CH_QUOTE,     1'b0, 1'b0, NO_SPAN},
        '{16'h0061,               1'b0, 1'b0, NO_SPAN},
        '{ncsl_pkg::CH_QUOTE,     1'b0, 1'b1,
          '{ncsl_pkg::KIND_STRING, 12'd0, 13'd3, 1'b0, 1'b0, 8'd0, 1'b0}},
        '{ncsl_pkg::CH_SLASH,     1'b0, 1'b0, NO_SPAN},
        '{ncsl_pkg::CH_STAR,      1'b0, 1'b0, NO_SPAN},
        '{ncsl_pkg::CH_STAR,      1'b0, 1'b0, NO_SPAN},
        '{ncsl_pkg::CH_SLASH,     1'b1, 1'b1,
          '{ncsl_pkg::KIND_COMMENT, 12'd3, 13'd4, 1'b1, 1'b0, 8'd0, 1'b0}},
        // A closer at depth zero, then an escaped quote and the top code unit.
        '{ncsl_pkg::CH_STAR,      1'b0, 1'b0, NO_SPAN},
        '{ncsl_pkg::CH_SLASH,     1'b0, 1'b1,
          '{ncsl_pkg::KIND_ERROR, 12'd0, 13'd2, 1'b0, 1'b0, 8'd0, 1'b0}},
        '{ncsl_pkg::CH_BACKSLASH, 1'b0, 1'b0, NO_SPAN},
        '{ncsl_pkg::CH_QUOTE,     1'b0, 1'b0, NO_SPAN},
        '{16'hFFFF,               1'b1, 1'b1,
          '{ncsl_pkg::KIND_NONE, 12'd0, 13'd0, 1'b1, 1'b0, 8'd0, 1'b0}},
        // Two nested openers and one closer leave depth one open at the line end.
        '{ncsl_pkg::CH_SLASH,     1'b0, 1'b0, NO_SPAN},
        '{ncsl_pkg::CH_STAR,      1'b0, 1'b0, NO_SPAN},
        '{ncsl_pkg::CH_SLASH,     1'b0, 1'b0, NO_SPAN},
        '{ncsl_pkg::CH_STAR,      1'b0, 1'b0, NO_SPAN},
        '{ncsl_pkg::CH_STAR,      1'b0, 1'b0, NO_SPAN},
        '{ncsl_pkg::CH_SLASH,     1'b1, 1'b1,
          '{ncsl_pkg::KIND_COMMENT, 12'd0, 13'd6, 1'b1, 1'b0, 8'd1, 1'b0}},
        // The carried comment restarts at zero; a quote inside it is plain text.
        '{ncsl_pkg::CH_QUOTE,     1'b0, 1'b0, NO_SPAN},
        '{ncsl_pkg::CH_STAR,      1'b0, 1'b0, NO_SPAN},
        '{ncsl_pkg::CH_SLASH,     1'b0, 1'b1,
          '{ncsl_pkg::KIND_COMMENT, 12'd0, 13'd3, 1'b0, 1'b0, 8'd0, 1'b0}},
        '{ncsl_pkg::CH_QUOTE,     1'b0, 1'b0, NO_SPAN},
        '{16'h0000,               1'b1, 1'b1,
          '{ncsl_pkg::KIND_STRING, 12'd3, 13'd2, 1'b1, 1'b1, 8'd0, 1'b0}},
        // The carried string skips an escaped quote and closes on the last one.
        '{ncsl_pkg::CH_BACKSLASH, 1'b0, 1'b0, NO_SPAN},
        '{ncsl_pkg::CH_QUOTE,     1'b0, 1'b0, NO_SPAN},
        '{ncsl_pkg::CH_QUOTE,     1'b1, 1'b1,
          '{ncsl_pkg::KIND_STRING, 12'd0, 13'd3, 1'b1, 1'b0, 8'd0, 1'b0}},
        // A slash and a star on separate lines never form an opener.
        '{ncsl_pkg::CH_SLASH,     1'b1, 1'b1,
          '{ncsl_pkg::KIND_NONE, 12'd0, 13'd0, 1'b1, 1'b0, 8'd0, 1'b0}},
        '{ncsl_pkg::CH_STAR,      1'b1, 1'b1,
          '{ncsl_pkg::KIND_NONE, 12'd0, 13'd0, 1'b1, 1'b0, 8'd0, 1'b0}}
    };

    logic                          i_clk;
    logic                          i_rst_n       = 1'b0;
    logic                          i_valid       = 1'b0;
    logic [ncsl_pkg::CHAR_W-1:0]   i_char_code   = '0;
    logic                          i_end_of_line = 1'b0;
    logic                          i_stall       = 1'b0;
    logic                          o_stall;
    logic                          o_valid;
    logic [1:0]                    o_span_kind;
    logic [ncsl_pkg::START_W-1:0]  o_span_start;
    logic [ncsl_pkg::LEN_W-1:0]    o_span_length;
    logic                          o_line_done;
    logic                          o_end_in_string;
    logic [ncsl_pkg::DEPTH_W-1:0]  o_end_comment_depth;
    logic                          o_overflow;

    nested_comment_string_lexer_unit uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_char_code         (i_char_code),
        .i_end_of_line       (i_end_of_line),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_span_kind         (o_span_kind),
        .o_span_start        (o_span_start),
        .o_span_length       (o_span_length),
        .o_line_done         (o_line_done),
        .o_end_in_string     (o_end_in_string),
        .o_end_comment_depth (o_end_comment_depth),
        .o_overflow          (o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Lexer state as the predictor sees it; the initial values are the reset state.
    logic                          lx_in_str = 1'b0;
    logic [ncsl_pkg::DEPTH_W-1:0]  lx_depth  = '0;
    logic                          lx_skip   = 1'b0;
    logic                          lx_slash  = 1'b0;
    logic                          lx_star   = 1'b0;
    logic [ncsl_pkg::START_W-1:0]  lx_open   = '0;
    logic [ncsl_pkg::LEN_W-1:0]    lx_pos    = '0;
    logic                          lx_ovf    = 1'b0;

    t_span_rep   pending_spans [$];
    t_dir_row    typed_q [$];
    logic [ncsl_pkg::CHAR_W-1:0] line_buf [$];
    int          mismatches  = 0;
    int          rand_items  = 0;
    int          burst_left  = 0;
    int          idle_cycles = 0;
    int          stall_phase = 0;
    int          stall_mode  = 0;
    t_span_rep   lexed;
    t_span_rep   want;
    t_dir_row    taken;

    // Advances the lexer state by one character and returns 1 when it yields a span report.
    function automatic bit lex_char(input logic [ncsl_pkg::CHAR_W-1:0] ch, input logic eol,
                                    output t_span_rep rep);
        logic [ncsl_pkg::LEN_W-1:0]   cur;
        logic [ncsl_pkg::LEN_W-1:0]   end_pos;
        logic [ncsl_pkg::START_W-1:0] cs;
        logic [ncsl_pkg::START_W-1:0] ps;
        rep = '0;
        cur = lx_pos;
        // Past the line limit every character sits on the last position.
        if (cur >= LINE_CAP) begin
            cur = LINE_CAP;
            lx_ovf = 1'b1;
        end
        cs = (cur < LINE_CAP) ? cur[ncsl_pkg::START_W-1:0]
                              : ncsl_pkg::START_W'(LINE_CAP - 1);
        ps = (cur == 0) ? '0 : ((cur < LINE_CAP) ? ncsl_pkg::START_W'(cur - 1)
                                                 : ncsl_pkg::START_W'(LINE_CAP - 1));
        end_pos = (cur < LINE_CAP) ? cur + 1'b1 : ncsl_pkg::LEN_W'(LINE_CAP);

        if (lx_skip) begin
            lx_skip = 1'b0;
        end else if (lx_slash && ch == ncsl_pkg::CH_STAR) begin
            lx_slash = 1'b0;
            if (lx_depth == 0) lx_open = ps;
            if (lx_depth < DEPTH_CAP) lx_depth = lx_depth + 1'b1;
            else lx_ovf = 1'b1;
        end else if (lx_star && ch == ncsl_pkg::CH_SLASH) begin
            lx_star = 1'b0;
            if (lx_depth == 0) begin
                rep.kind = ncsl_pkg::KIND_ERROR;
                rep.span_start = ps;
                rep.span_len = end_pos - ps;
            end else begin
                if (lx_depth == 1) begin
                    rep.kind = ncsl_pkg::KIND_COMMENT;
                    rep.span_start = lx_open;
                    rep.span_len = end_pos - lx_open;
                end
                lx_depth = lx_depth - 1'b1;
            end
        end else begin
            lx_slash = 1'b0;
            lx_star = 1'b0;
            if (ch == ncsl_pkg::CH_BACKSLASH) begin
                lx_skip = 1'b1;
            end else if (ch == ncsl_pkg::CH_QUOTE && lx_depth == 0) begin
                if (!lx_in_str) begin
                    lx_open = cs;
                end else begin
                    rep.kind = ncsl_pkg::KIND_STRING;
                    rep.span_start = lx_open;
                    rep.span_len = end_pos - lx_open;
                end
                lx_in_str = !lx_in_str;
            end else if (ch == ncsl_pkg::CH_SLASH && !lx_in_str) begin
                lx_slash = 1'b1;
            end else if (ch == ncsl_pkg::CH_STAR && !lx_in_str) begin
                lx_star = 1'b1;
            end
        end

        if (lx_pos < LINE_CAP) lx_pos = lx_pos + 1'b1;
        if (!eol) return rep.kind != ncsl_pkg::KIND_NONE;

        // At the line end an open span runs to the end of the line.
        if (rep.kind == ncsl_pkg::KIND_NONE && (lx_in_str || lx_depth != 0)) begin
            rep.kind = lx_in_str ? ncsl_pkg::KIND_STRING : ncsl_pkg::KIND_COMMENT;
            rep.span_start = lx_open;
            rep.span_len = end_pos - lx_open;
        end
        rep.done = 1'b1;
        rep.in_str = lx_in_str;
        rep.depth = lx_depth;
        rep.ovf = lx_ovf;
        lx_skip = 1'b0;
        lx_slash = 1'b0;
        lx_star = 1'b0;
        lx_open = '0;
        lx_pos = '0;
        lx_ovf = 1'b0;
        return 1'b1;
    endfunction

    // Weighted toward the characters the lexer reacts to.
    function automatic logic [ncsl_pkg::CHAR_W-1:0] pick_char();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 14) return ncsl_pkg::CH_QUOTE;
        if (sel < 28) return ncsl_pkg::CH_SLASH;
        if (sel < 42) return ncsl_pkg::CH_STAR;
        if (sel < 50) return ncsl_pkg::CH_BACKSLASH;
        if (sel < 85) return ncsl_pkg::CHAR_W'($urandom_range(32, 126));
        return ncsl_pkg::CHAR_W'($urandom());
    endfunction

    // Fills line_buf with at least n characters: loose characters, strings, comments, escapes and closers.
    task automatic build_line(input int n);
        int sel;
        line_buf.delete();
        while (line_buf.size() < n) begin
            sel = $urandom_range(0, 99);
            if (sel < 30) begin
                line_buf.push_back(pick_char());
            end else if (sel < 50) begin
                line_buf.push_back(ncsl_pkg::CH_QUOTE);
                repeat ($urandom_range(0, 6))
                    line_buf.push_back(ncsl_pkg::CHAR_W'($urandom_range(35, 126)));
                line_buf.push_back(ncsl_pkg::CH_QUOTE);
            end else if (sel < 68) begin
                line_buf.push_back(ncsl_pkg::CH_SLASH);
                line_buf.push_back(ncsl_pkg::CH_STAR);
                repeat ($urandom_range(0, 5)) line_buf.push_back(pick_char());
                if ($urandom_range(0, 3) == 0) begin
                    line_buf.push_back(ncsl_pkg::CH_SLASH);
                    line_buf.push_back(ncsl_pkg::CH_STAR);
                    line_buf.push_back(ncsl_pkg::CHAR_W'($urandom_range(97, 122)));
                    line_buf.push_back(ncsl_pkg::CH_STAR);
                    line_buf.push_back(ncsl_pkg::CH_SLASH);
                end
                line_buf.push_back(ncsl_pkg::CH_STAR);
                line_buf.push_back(ncsl_pkg::CH_SLASH);
            end else if (sel < 78) begin
                line_buf.push_back(ncsl_pkg::CH_BACKSLASH);
                line_buf.push_back(pick_char());
            end else if (sel < 88) begin
                line_buf.push_back(ncsl_pkg::CH_STAR);
                line_buf.push_back(ncsl_pkg::CH_SLASH);
            end else begin
                line_buf.push_back(ncsl_pkg::CHAR_W'($urandom()));
            end
        end
    endtask

    // Sends one character, opening a new burst after a random gap when the last one ran out.
    task automatic send_row(input t_dir_row row);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
        end
        typed_q.push_back(row);
        i_valid       <= 1'b1;
        i_char_code   <= row.ch;
        i_end_of_line <= row.eol;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        burst_left--;
    endtask

    // Sends line_buf with the end-of-line mark on its last character.
    task automatic send_line();
        t_dir_row row;
        for (int i = 0; i < line_buf.size(); i++) begin
            row = '0;
            row.ch = line_buf[i];
            row.eol = (i == line_buf.size() - 1);
            send_row(row);
        end
        rand_items += line_buf.size();
    endtask

    // Holds the sender off until every predicted report has come out.
    task automatic drain_pause();
        i_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending_spans.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    // Every accepted character goes through the predictor; pinned rows use their typed report.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            taken = typed_q.pop_front();
            if (taken.pinned) begin
                void'(lex_char(i_char_code, i_end_of_line, lexed));
                pending_spans.push_back(taken.rep);
            end else if (lex_char(i_char_code, i_end_of_line, lexed)) begin
                pending_spans.push_back(lexed);
            end
        end
    end

    // Each accepted report is compared with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_spans.size() == 0) begin
                mismatches++;
                $display("%0t ns: span report with none expected, actual kind %0d start %0d len %0d",
                         $time, o_span_kind, o_span_start, o_span_length);
            end else begin
                want = pending_spans.pop_front();
                check_field("span_kind", want.kind, o_span_kind);
                check_field("span_start", want.span_start, o_span_start);
                check_field("span_length", want.span_len, o_span_length);
                check_field("line_done", want.done, o_line_done);
                check_field("end_in_string", want.in_str, o_end_in_string);
                check_field("end_comment_depth", want.depth, o_end_comment_depth);
                check_field("overflow", want.ovf, o_overflow);
            end
        end
    end

    // The receiver switches between free flow, light, heavy and periodic stalls.
    always @(posedge i_clk) begin
        if (stall_phase == 0) begin
            stall_mode  <= $urandom_range(0, 3);
            stall_phase <= $urandom_range(16, 96);
        end else begin
            stall_phase <= stall_phase - 1;
        end
        case (stall_mode)
            0: begin
                i_stall <= 1'b0;
            end
            1: begin
                i_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
                i_stall <= ($urandom_range(0, 9) < 7);
            end
            default: begin
                i_stall <= (stall_phase % 3 == 0);
            end
        endcase
    end

    // A run that stops moving transactions in either direction is a failure.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_N; i++) send_row(DIR_TAB[i]);
        drain_pause();

        while (rand_items < RAND_GOAL) begin
            build_line(($urandom_range(0, 6) == 0) ? $urandom_range(25, 120)
                                                   : $urandom_range(1, 24));
            send_line();
        end
        drain_pause();

        // One opener past the depth limit sets overflow; the next line closes one
        // level of the saturated nesting and carries the rest.
        line_buf.delete();
        repeat (DEPTH_CAP + 1) begin
            line_buf.push_back(ncsl_pkg::CH_SLASH);
            line_buf.push_back(ncsl_pkg::CH_STAR);
        end
        line_buf.push_back(16'h0071);
        send_line();
        line_buf.delete();
        line_buf.push_back(ncsl_pkg::CH_STAR);
        line_buf.push_back(ncsl_pkg::CH_SLASH);
        send_line();

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_spans.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_spans.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
